[rtl/cbpm_pkg.sv]
`timescale 1ns / 1ps

package cbpm_pkg;

  // Level in centibels, two's complement
  localparam int CB_W = 11;
  typedef logic signed [CB_W-1:0] cb_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD   = 1'b1;

  // Register reset values
  localparam logic [15:0] FULL_SCALE_RESET = 16'd3000;
  localparam logic [15:0] OVERLOAD_RESET   = 16'd4500;
  // Level of the reset full-scale amplitude (3000 -> 7 shifts, fine index 23)
  localparam cb_t FULL_SCALE_CB_RESET = 11'sd695;

  // Color codes
  localparam logic [1:0] COLOR_GREY  = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_RED   = 2'd2;

  // Level thresholds and bar floor
  localparam cb_t LVL_RED   = -11'sd3;
  localparam cb_t LVL_GREEN = -11'sd130;
  localparam cb_t LVL_FLOOR = -11'sd280;
  localparam cb_t LVL_TOP   = 11'sd0;

  // Fine log table over the normalized mantissa 0..31
  localparam cb_t FINE_LOG [32] = '{
    -11'sd1,  11'sd0,   11'sd60,  11'sd95,  11'sd120, 11'sd140, 11'sd156, 11'sd169,
    11'sd181, 11'sd191, 11'sd200, 11'sd208, 11'sd216, 11'sd223, 11'sd229, 11'sd235,
    11'sd243, 11'sd249, 11'sd253, 11'sd258, 11'sd262, 11'sd266, 11'sd270, 11'sd274,
    11'sd278, 11'sd281, 11'sd285, 11'sd288, 11'sd291, 11'sd294, 11'sd297, 11'sd300
  };

  // Coarse level for a shift count: (shifts * 301 + 2) / 5
  function automatic cb_t coarse_cb(input logic [3:0] shifts);
    cb_t val;
    unique case (shifts)
      4'd0:    val = 11'sd0;
      4'd1:    val = 11'sd60;
      4'd2:    val = 11'sd120;
      4'd3:    val = 11'sd181;
      4'd4:    val = 11'sd241;
      4'd5:    val = 11'sd301;
      4'd6:    val = 11'sd361;
      4'd7:    val = 11'sd421;
      4'd8:    val = 11'sd482;
      4'd9:    val = 11'sd542;
      4'd10:   val = 11'sd602;
      4'd11:   val = 11'sd662;
      default: val = 11'sd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/cbpm_log.sv]
`timescale 1ns / 1ps

module cbpm_log (
  input  logic [15:0]  amp,
  output cbpm_pkg::cb_t cb
);
  import cbpm_pkg::*;

  logic [3:0] shift4;
  logic [7:0] amp_mid;
  logic [3:0] shift1;
  logic [4:0] mant;

  // Normalize by nibbles while at least 256
  always_comb begin
    priority if (amp >= 16'd4096) shift4 = 4'd8;
    else if (amp >= 16'd256)      shift4 = 4'd4;
    else                          shift4 = 4'd0;
  end

  assign amp_mid = 8'(amp >> shift4);

  // Normalize by single bits while at least 32
  always_comb begin
    priority if (amp_mid[7]) shift1 = 4'd3;
    else if (amp_mid[6])     shift1 = 4'd2;
    else if (amp_mid[5])     shift1 = 4'd1;
    else                     shift1 = 4'd0;
  end

  assign mant = 5'(amp_mid >> shift1);

  // Zero amplitude lands on the table's -1 entry with no shifts
  assign cb = coarse_cb(shift4 + shift1) + FINE_LOG[mant];

endmodule

[rtl/cbpm_pick.sv]
`timescale 1ns / 1ps

module cbpm_pick #(
  parameter int REDRAW_EVERY = 5
) (
  input  logic [31:0] frame,
  output logic        pick
);
  localparam int MW = (REDRAW_EVERY > 1) ? $clog2(REDRAW_EVERY) : 1;

  logic [MW-1:0] byte_res [4][256];
  logic [MW-1:0] fold_res [256];
  logic [7:0]    res_sum;

  // Residue tables: byte value times its weight, reduced by the redraw period
  for (genvar k = 0; k < 4; k++) begin : g_byte
    localparam int WT = (1 << (8 * k)) % REDRAW_EVERY;
    for (genvar b = 0; b < 256; b++) begin : g_entry
      assign byte_res[k][b] = MW'((b * WT) % REDRAW_EVERY);
    end
  end

  for (genvar s = 0; s < 256; s++) begin : g_fold
    assign fold_res[s] = MW'(s % REDRAW_EVERY);
  end

  // Sum the byte residues, then fold once more
  assign res_sum = 8'(byte_res[0][frame[7:0]])   + 8'(byte_res[1][frame[15:8]]) +
                   8'(byte_res[2][frame[23:16]]) + 8'(byte_res[3][frame[31:24]]);

  assign pick = (fold_res[res_sum] == MW'(1 % REDRAW_EVERY));

endmodule

[rtl/centibel_peak_meter.sv]
`timescale 1ns / 1ps

// Peak level meter: turns one frame's peak amplitude and radio status into
// one bar redraw / clear result per item.
// Input stream: in_tdata carries peak_level and frame_count, in_tuser the
// transmit, receive and menu flags. Output stream: out_tdata carries
// bar_length, bar_color and relative_level, out_tuser draw_bar and
// clear_meter. The cfg channel writes full_scale_amplitude (index 0) and
// overload_limit (index 1); it is always ready and the user must use it only
// while idle, which the block does not enforce. Throughput: one item per cycle
// while the receiver keeps up. An accepted item is held in the input register,
// passes the log, compare and hold-counter logic combinationally and lands in
// the output register when it advances, raising out_tvalid. The meter state
// updates in that same step. When the receiver stalls, the result waits in the
// output register and one more item waits in the input register; in_tready
// drops only when both are full. Reset (rst_n low, synchronous) empties both
// registers, clears the last frame seen, the shown flag and both hold counters,
// and loads the configuration reset values (3000 full scale, 4500 overload).
module centibel_peak_meter #(
  parameter int REDRAW_EVERY = 5,
  parameter int HOLD_REDRAWS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] peak_level, [47:16] frame_count
  input  logic [2:0]  in_tuser,   // [0] transmitting, [1] receiving, [2] menu_open
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] bar_length, [9:8] bar_color,
                                  // [20:10] relative_level, [23:21] zero
  output logic [1:0]  out_tuser,  // [0] draw_bar, [1] clear_meter
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cbpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import cbpm_pkg::*;

  localparam int HOLD_W = $clog2(HOLD_REDRAWS + 1);

  // Configuration
  logic [15:0] overload_r;
  cb_t         fs_cb_r;
  cb_t         cfg_cb;

  // Input register
  logic        in_v_r;
  logic [15:0] peak_r;
  logic [31:0] frame_r;
  logic        tx_r, rx_r, menu_r, pick_r;
  logic        pick_in;

  // Meter state
  logic [31:0]       last_frame_r, last_frame_nxt;
  logic              shown_r, shown_nxt;
  logic [HOLD_W-1:0] red_hold_r, red_hold_nxt;
  logic [HOLD_W-1:0] green_hold_r, green_hold_nxt;

  // Output register
  logic        out_v_r;
  logic        draw_r, draw_nxt;
  logic [7:0]  bar_r, bar_nxt;
  logic [1:0]  color_r, color_nxt;
  cb_t         rel_r, rel_nxt;
  logic        clear_r, clear_nxt;

  // Datapath
  cb_t  peak_cb, rel, clamped, lifted;
  logic frame_ok, hot, warm, adv;

  assign cfg_ready = 1'b1;

  // Level of a new full-scale value, taken at the write
  cbpm_log u_cfg_log (
    .amp (cfg_data),
    .cb  (cfg_cb)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_cb_r    <= FULL_SCALE_CB_RESET;
      overload_r <= OVERLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FULL_SCALE: fs_cb_r    <= cfg_cb;
        REG_OVERLOAD:   overload_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Redraw pick from the frame count, ahead of the input register
  cbpm_pick #(
    .REDRAW_EVERY (REDRAW_EVERY)
  ) u_pick (
    .frame (in_tdata[47:16]),
    .pick  (pick_in)
  );

  // Advance when the input register holds an item and the output can take it
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  // Capture an input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      peak_r  <= in_tdata[15:0];
      frame_r <= in_tdata[47:16];
      tx_r    <= in_tuser[0];
      rx_r    <= in_tuser[1];
      menu_r  <= in_tuser[2];
      pick_r  <= pick_in;
    end
  end

  // Peak level relative to full scale
  cbpm_log u_peak_log (
    .amp (peak_r),
    .cb  (peak_cb)
  );

  assign rel      = peak_cb - fs_cb_r;
  assign frame_ok = tx_r && (peak_r < overload_r) && (last_frame_r < frame_r);
  assign hot      = rel > LVL_RED;
  assign warm     = rel > LVL_GREEN;

  // Clamp to the bar range and shift to a pixel count
  always_comb begin
    priority if (rel < LVL_FLOOR) clamped = LVL_FLOOR;
    else if (rel > LVL_TOP)       clamped = LVL_TOP;
    else                          clamped = rel;
  end

  assign lifted = clamped - LVL_FLOOR;

  // Meter state and result for the held item
  always_comb begin
    last_frame_nxt = last_frame_r;
    shown_nxt      = shown_r;
    red_hold_nxt   = red_hold_r;
    green_hold_nxt = green_hold_r;
    draw_nxt       = 1'b0;
    bar_nxt        = 8'd0;
    color_nxt      = COLOR_GREY;
    rel_nxt        = '0;
    clear_nxt      = 1'b0;
    if (!menu_r) begin
      if (frame_ok) begin
        last_frame_nxt = frame_r;
        shown_nxt      = 1'b1;
        rel_nxt        = rel;
        if (pick_r) begin
          draw_nxt = 1'b1;
          bar_nxt  = lifted[8:1];
          priority if (hot || (red_hold_r != '0)) begin
            if (red_hold_r != '0) red_hold_nxt = red_hold_r - HOLD_W'(1);
            if (hot) red_hold_nxt = HOLD_W'(HOLD_REDRAWS);
            color_nxt = COLOR_RED;
          end else if (warm || (green_hold_r != '0)) begin
            if (green_hold_r != '0) green_hold_nxt = green_hold_r - HOLD_W'(1);
            if (warm) green_hold_nxt = HOLD_W'(HOLD_REDRAWS);
            color_nxt = COLOR_GREEN;
          end else begin
            color_nxt = COLOR_GREY;
          end
        end
      end
      // Receive clears a shown meter after the frame is handled
      if (rx_r && shown_nxt) begin
        clear_nxt      = 1'b1;
        shown_nxt      = 1'b0;
        red_hold_nxt   = '0;
        green_hold_nxt = '0;
      end
    end
  end

  // Update meter state as an item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frame_r <= '0;
      shown_r      <= 1'b0;
      red_hold_r   <= '0;
      green_hold_r <= '0;
    end else if (adv) begin
      last_frame_r <= last_frame_nxt;
      shown_r      <= shown_nxt;
      red_hold_r   <= red_hold_nxt;
      green_hold_r <= green_hold_nxt;
    end
  end

  // Output register: load on advance, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      draw_r  <= draw_nxt;
      bar_r   <= bar_nxt;
      color_r <= color_nxt;
      rel_r   <= rel_nxt;
      clear_r <= clear_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, rel_r, color_r, bar_r};
  assign out_tuser  = {clear_r, draw_r};

endmodule
